### rtl/core/i2cbc_pkg.sv
// i2cbc_pkg: shared types and constants for the i2c bus-clear sequencer
// no dependencies; used by the top level and its checker

package i2cbc_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SETTLE    = 3'd1,
        PH_STRETCH   = 3'd2,
        PH_CLK_LOW   = 3'd3,
        PH_CLK_WAIT  = 3'd4,
        PH_CLK_HIGH  = 3'd5,
        PH_STOP_LOW  = 3'd6,
        PH_STOP_HIGH = 3'd7
    } phase_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_HALF_PERIOD = 2'd0,
        REG_STRETCH_TO  = 2'd1,
        REG_PULSE_WAIT  = 2'd2,
        REG_MAX_PULSES  = 2'd3
    } cfg_reg_t;

    // line drive bits: bit 0 pulls sda low, bit 1 pulls scl low
    localparam logic [1:0] DRV_NONE = 2'b00;
    localparam logic [1:0] DRV_SDA  = 2'b01;
    localparam logic [1:0] DRV_SCL  = 2'b10;

    // widths
    localparam int HALF_W   = 10;
    localparam int TO_W     = 16;
    localparam int PULSE_W  = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 16;

    // output field positions in m_tdata
    localparam int O_SDA_DRV = 0;
    localparam int O_SCL_DRV = 1;
    localparam int O_BUSY    = 2;
    localparam int O_DONE    = 3;
    localparam int O_OK      = 4;
    localparam int O_STUCK   = 5;
    localparam int O_PULSE_L = 6;

    // reset values and defaults
    localparam logic [HALF_W-1:0]  HALF_RST    = 10'd5;
    localparam logic [TO_W-1:0]    STRETCH_RST = 16'd10000;
    localparam logic [TO_W-1:0]    PWAIT_RST   = 16'd1000;
    localparam logic [PULSE_W-1:0] MAXP_RST    = 5'd16;
    localparam int TIMER_BITS_DEF = 16;

endpackage

### rtl/core/i2c_bus_clear_sequencer_top.sv
// i2c_bus_clear_sequencer_top: bus-clear recovery sequencer, one result per tick
// depends on i2cbc_pkg; checked by i2cbc_checker (bound in its own file)
//
//  channel | signals                         | payload
//  --------+---------------------------------+--------------------------------------
//  in      | s_tvalid s_tready s_tdata[7:0]  | one time-base tick with line levels
//  out     | m_tvalid m_tready m_tdata[15:0] | drive bits, status, pulse count
//  cfg     | cfg_we cfg_index cfg_data[15:0] | register write, no read-back
//
// each accepted tick goes through the phase logic combinationally and its result
// sits in the output register in the following cycle; a new tick is taken every cycle
// while the output register is empty or being drained (s_tready = !m_tvalid | m_tready)
// one tick per cycle sustained while m_tready stays high
// rst_n clears the phase state, counters and the output valid, and loads the config registers with their defaults

`default_nettype none

module i2c_bus_clear_sequencer_top #(
    parameter int TIMER_BITS = i2cbc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // in transfer
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: [0] start_req, [1] sda_level, [2] scl_level, [7:3] zero
    input  wire logic [i2cbc_pkg::IN_W-1:0]          s_tdata,
    // out transfer
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata: [0] sda_drive_low, [1] scl_drive_low, [2] busy_res, [3] done_res,
    //          [4] bus_ok, [5] scl_stuck, [10:6] pulses_issued, [15:11] zero
    output logic [i2cbc_pkg::OUT_W-1:0]              m_tdata,
    // config write port
    input  wire logic                                cfg_we,
    input  wire logic [i2cbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [i2cbc_pkg::CFG_W-1:0]         cfg_data
);

    // compare width: wide enough for the timer and the 16-bit limits
    localparam int CW = (TIMER_BITS > i2cbc_pkg::TO_W) ? TIMER_BITS : i2cbc_pkg::TO_W;
    localparam logic [CW-1:0]         TMAX_CW = CW'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [TIMER_BITS-1:0] TMAX    = '1;

    // config registers
    logic [i2cbc_pkg::HALF_W-1:0]  half_reg;
    logic [i2cbc_pkg::TO_W-1:0]    stretch_reg;
    logic [i2cbc_pkg::TO_W-1:0]    pwait_reg;
    logic [i2cbc_pkg::PULSE_W-1:0] maxp_reg;

    // sequencer state
    i2cbc_pkg::phase_t             phase_reg, phase_next;
    logic [TIMER_BITS-1:0]         tick_reg, tick_next;
    logic [i2cbc_pkg::PULSE_W-1:0] pulse_reg, pulse_next;
    logic                          stuck_reg, stuck_next;
    logic [1:0]                    drive_reg, drive_next;

    // output register
    logic                          out_valid_reg;
    logic [i2cbc_pkg::OUT_W-1:0]   out_data_reg, out_data_next;

    logic                          s_acc;
    logic                          start, sda, scl;
    logic [TIMER_BITS-1:0]         tick_inc;
    logic [CW-1:0]                 tick_cw, tick_inc_cw;
    logic [CW-1:0]                 half_lim, stretch_lim, pwait_lim;
    logic                          dec_req, fin_req, fin_ok, done_now;

    // clamp a limit to the largest timer count
    function automatic logic [CW-1:0] clamp_lim(input logic [i2cbc_pkg::TO_W-1:0] v);
        logic [CW-1:0] ve;
        ve = CW'(v);
        return (ve > TMAX_CW) ? TMAX_CW : ve;
    endfunction

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign start = s_tdata[0];
    assign sda   = s_tdata[1];
    assign scl   = s_tdata[2];

    // saturating tick count and limits
    assign tick_inc    = (tick_reg < TMAX) ? TIMER_BITS'(tick_reg + 1'b1) : tick_reg;
    assign tick_cw     = CW'(tick_reg);
    assign tick_inc_cw = CW'(tick_inc);
    assign half_lim    = clamp_lim(i2cbc_pkg::TO_W'(half_reg));
    assign stretch_lim = clamp_lim(stretch_reg);
    assign pwait_lim   = clamp_lim(pwait_reg);

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= i2cbc_pkg::HALF_RST;
            stretch_reg <= i2cbc_pkg::STRETCH_RST;
            pwait_reg   <= i2cbc_pkg::PWAIT_RST;
            maxp_reg    <= i2cbc_pkg::MAXP_RST;
        end
        else if (cfg_we)
        begin
            case (i2cbc_pkg::cfg_reg_t'(cfg_index))
                i2cbc_pkg::REG_HALF_PERIOD: half_reg    <= cfg_data[i2cbc_pkg::HALF_W-1:0];
                i2cbc_pkg::REG_STRETCH_TO:  stretch_reg <= cfg_data[i2cbc_pkg::TO_W-1:0];
                i2cbc_pkg::REG_PULSE_WAIT:  pwait_reg   <= cfg_data[i2cbc_pkg::TO_W-1:0];
                i2cbc_pkg::REG_MAX_PULSES:  maxp_reg    <= cfg_data[i2cbc_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    // phase logic for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        pulse_next = pulse_reg;
        stuck_next = stuck_reg;
        drive_next = drive_reg;
        dec_req    = 1'b0;
        fin_req    = 1'b0;
        fin_ok     = 1'b0;

        case (phase_reg)
            i2cbc_pkg::PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = i2cbc_pkg::PH_SETTLE;
                    tick_next  = '0;
                    pulse_next = '0;
                    stuck_next = 1'b0;
                    drive_next = i2cbc_pkg::DRV_NONE;
                end
            end
            i2cbc_pkg::PH_SETTLE:
            begin
                tick_next = tick_inc;
                if (tick_inc_cw >= half_lim)
                begin
                    tick_next = '0;
                    if (sda && scl)
                    begin
                        fin_req = 1'b1;
                        fin_ok  = 1'b1;
                    end
                    else if (!scl)
                        phase_next = i2cbc_pkg::PH_STRETCH;
                    else
                        dec_req = 1'b1;
                end
            end
            i2cbc_pkg::PH_STRETCH:
            begin
                if (scl)
                    dec_req = 1'b1;
                else if (tick_cw >= stretch_lim)
                begin
                    stuck_next = 1'b1;
                    fin_req    = 1'b1;
                end
                else
                    tick_next = tick_inc;
            end
            i2cbc_pkg::PH_CLK_LOW:
            begin
                tick_next = tick_inc;
                if (tick_inc_cw >= half_lim)
                begin
                    drive_next = i2cbc_pkg::DRV_NONE;
                    tick_next  = '0;
                    phase_next = i2cbc_pkg::PH_CLK_WAIT;
                end
            end
            i2cbc_pkg::PH_CLK_WAIT:
            begin
                if (scl || (tick_cw >= pwait_lim))
                begin
                    tick_next  = '0;
                    phase_next = i2cbc_pkg::PH_CLK_HIGH;
                end
                else
                    tick_next = tick_inc;
            end
            i2cbc_pkg::PH_CLK_HIGH:
            begin
                tick_next = tick_inc;
                if (tick_inc_cw >= half_lim)
                begin
                    pulse_next = pulse_reg + 1'b1;
                    dec_req    = 1'b1;
                end
            end
            i2cbc_pkg::PH_STOP_LOW:
            begin
                tick_next = tick_inc;
                if (tick_inc_cw >= half_lim)
                begin
                    drive_next = i2cbc_pkg::DRV_NONE;
                    tick_next  = '0;
                    phase_next = i2cbc_pkg::PH_STOP_HIGH;
                end
            end
            i2cbc_pkg::PH_STOP_HIGH:
            begin
                tick_next = tick_inc;
                if (tick_inc_cw >= half_lim)
                begin
                    fin_req = 1'b1;
                    fin_ok  = sda && scl;
                end
            end
            default:
            begin
                phase_next = i2cbc_pkg::PH_IDLE;
                drive_next = i2cbc_pkg::DRV_NONE;
                tick_next  = '0;
            end
        endcase

        // next step after settle, stretch or a pulse: pulse again, stop, or finish
        if (dec_req)
        begin
            tick_next = '0;
            if (!sda && (pulse_next < maxp_reg))
            begin
                drive_next = i2cbc_pkg::DRV_SCL;
                phase_next = i2cbc_pkg::PH_CLK_LOW;
            end
            else if (sda && scl)
            begin
                drive_next = i2cbc_pkg::DRV_SDA;
                phase_next = i2cbc_pkg::PH_STOP_LOW;
            end
            else
            begin
                fin_req = 1'b1;
                fin_ok  = 1'b0;
            end
        end

        // finish: release lines and go idle
        if (fin_req)
        begin
            phase_next = i2cbc_pkg::PH_IDLE;
            drive_next = i2cbc_pkg::DRV_NONE;
            tick_next  = '0;
        end
    end

    assign done_now = fin_req;

    // result word from the state after this tick
    always_comb
    begin
        out_data_next = '0;
        out_data_next[i2cbc_pkg::O_SDA_DRV] = drive_next[0];
        out_data_next[i2cbc_pkg::O_SCL_DRV] = drive_next[1];
        out_data_next[i2cbc_pkg::O_BUSY]    = (phase_next != i2cbc_pkg::PH_IDLE);
        out_data_next[i2cbc_pkg::O_DONE]    = done_now;
        out_data_next[i2cbc_pkg::O_OK]      = done_now && fin_ok;
        out_data_next[i2cbc_pkg::O_STUCK]   = done_now && stuck_next;
        out_data_next[i2cbc_pkg::O_PULSE_L +: i2cbc_pkg::PULSE_W] = pulse_next;
    end

    // state registers advance on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= i2cbc_pkg::PH_IDLE;
            tick_reg  <= '0;
            pulse_reg <= '0;
            stuck_reg <= 1'b0;
            drive_reg <= i2cbc_pkg::DRV_NONE;
        end
        else if (s_acc)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            pulse_reg <= pulse_next;
            stuck_reg <= stuck_next;
            drive_reg <= drive_next;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_acc)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

### rtl/core/i2cbc_checker.sv
// i2cbc_checker: port-level assertions for the i2c bus-clear sequencer
// depends on i2cbc_pkg; bound to i2c_bus_clear_sequencer_top below

module i2cbc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [i2cbc_pkg::OUT_W-1:0]       m_tdata
);

    // a finished sequence is no longer busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[i2cbc_pkg::O_DONE] |-> !m_tdata[i2cbc_pkg::O_BUSY])
        else $error("done reported while busy");

    // outcome flags only with done, and never both
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[i2cbc_pkg::O_OK] || m_tdata[i2cbc_pkg::O_STUCK])
        |-> m_tdata[i2cbc_pkg::O_DONE]
            && !(m_tdata[i2cbc_pkg::O_OK] && m_tdata[i2cbc_pkg::O_STUCK]))
        else $error("bad outcome flags");

    // the sequencer never pulls both lines low together
    a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[i2cbc_pkg::O_SDA_DRV] && m_tdata[i2cbc_pkg::O_SCL_DRV]))
        else $error("both lines driven low");

    // input side is open whenever the output register is empty
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind i2c_bus_clear_sequencer_top i2cbc_checker u_i2cbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
